FILE: rtl/core/decimal_integer_formatter_core_macros.svh
// assertion macros for the decimal integer formatter core
`ifndef DECIMAL_INTEGER_FORMATTER_CORE_MACROS_SVH
`define DECIMAL_INTEGER_FORMATTER_CORE_MACROS_SVH

// same-cycle implication
`define DIF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dif assertion failed");

// next-cycle implication
`define DIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dif assertion failed");

`endif

FILE: rtl/core/dif_pkg.sv
// shared types, constants and microcode encodings for the decimal integer formatter
package dif_pkg;

   localparam int MAX_FIELD_DEFAULT = 64;
   localparam int MAX_DIGITS        = 10;
   localparam int DIGIT_BITS        = 4;

   localparam logic [31:0] RECIP10 = 32'hCCCCCCCD;
   localparam int          RECIP_SHIFT = 35;

   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;

   localparam logic OP_SIGNED   = 1'b0;
   localparam logic OP_UNSIGNED = 1'b1;

   typedef enum logic [2:0] {
      FLAG_NONE  = 3'd0,
      FLAG_LEFT  = 3'd1,
      FLAG_PLUS  = 3'd2,
      FLAG_SPACE = 3'd3,
      FLAG_ZERO  = 3'd4
   } flag_type;

   typedef struct packed {
      logic        operation;
      logic [31:0] value;
      logic        short_length;
      logic [2:0]  flag_mode;
      logic [6:0]  field_width;
      logic [5:0]  min_digits;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last_char;
   } rsp_payload_type;

   // microcode step addresses
   typedef logic [3:0] step_type;
   localparam step_type STEP_IDLE  = 4'd0;
   localparam step_type STEP_CONV  = 4'd1;
   localparam step_type STEP_CALC  = 4'd2;
   localparam step_type STEP_LPAD  = 4'd3;
   localparam step_type STEP_SIGN  = 4'd4;
   localparam step_type STEP_ZPAD  = 4'd5;
   localparam step_type STEP_PREC  = 4'd6;
   localparam step_type STEP_DIGIT = 4'd7;
   localparam step_type STEP_RPAD  = 4'd8;

   typedef enum logic [2:0] {
      DP_HOLD,
      DP_LOAD,
      DP_CONV,
      DP_CALC,
      DP_EMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      CS_SPACE,
      CS_ZERO,
      CS_SIGN,
      CS_DIGIT
   } char_sel_type;

   typedef enum logic [1:0] {
      CNT_PAD,
      CNT_SIGN,
      CNT_ZEROS,
      CNT_DIGITS
   } cnt_sel_type;

   typedef enum logic [1:0] {
      GATE_ALL,
      GATE_LEAD,
      GATE_ZERO,
      GATE_RIGHT
   } gate_type;

   typedef enum logic [1:0] {
      JC_START,
      JC_CONV,
      JC_PHASE,
      JC_ALWAYS
   } jump_cond_type;

   typedef struct packed {
      dp_op_type     dp_op;
      char_sel_type  char_sel;
      cnt_sel_type   cnt_sel;
      gate_type      gate;
      jump_cond_type jump_cond;
      step_type      target;
   } ctrl_word_type;

   typedef struct packed {
      logic conv_done;
      logic phase_done;
   } dp_status_type;

endpackage

FILE: rtl/core/dif_ucode_rom.sv
// control store: one control word per microcode step
module dif_ucode_rom (
   input  dif_pkg::step_type      step,
   output dif_pkg::ctrl_word_type ctrl_word
);

   always_comb begin
      case (step)
         dif_pkg::STEP_IDLE:  ctrl_word = '{dif_pkg::DP_LOAD, dif_pkg::CS_SPACE,
            dif_pkg::CNT_PAD, dif_pkg::GATE_ALL, dif_pkg::JC_START, dif_pkg::STEP_CONV};
         dif_pkg::STEP_CONV:  ctrl_word = '{dif_pkg::DP_CONV, dif_pkg::CS_SPACE,
            dif_pkg::CNT_PAD, dif_pkg::GATE_ALL, dif_pkg::JC_CONV, dif_pkg::STEP_CALC};
         dif_pkg::STEP_CALC:  ctrl_word = '{dif_pkg::DP_CALC, dif_pkg::CS_SPACE,
            dif_pkg::CNT_PAD, dif_pkg::GATE_ALL, dif_pkg::JC_ALWAYS, dif_pkg::STEP_LPAD};
         dif_pkg::STEP_LPAD:  ctrl_word = '{dif_pkg::DP_EMIT, dif_pkg::CS_SPACE,
            dif_pkg::CNT_PAD, dif_pkg::GATE_LEAD, dif_pkg::JC_PHASE, dif_pkg::STEP_SIGN};
         dif_pkg::STEP_SIGN:  ctrl_word = '{dif_pkg::DP_EMIT, dif_pkg::CS_SIGN,
            dif_pkg::CNT_SIGN, dif_pkg::GATE_ALL, dif_pkg::JC_PHASE, dif_pkg::STEP_ZPAD};
         dif_pkg::STEP_ZPAD:  ctrl_word = '{dif_pkg::DP_EMIT, dif_pkg::CS_ZERO,
            dif_pkg::CNT_PAD, dif_pkg::GATE_ZERO, dif_pkg::JC_PHASE, dif_pkg::STEP_PREC};
         dif_pkg::STEP_PREC:  ctrl_word = '{dif_pkg::DP_EMIT, dif_pkg::CS_ZERO,
            dif_pkg::CNT_ZEROS, dif_pkg::GATE_ALL, dif_pkg::JC_PHASE, dif_pkg::STEP_DIGIT};
         dif_pkg::STEP_DIGIT: ctrl_word = '{dif_pkg::DP_EMIT, dif_pkg::CS_DIGIT,
            dif_pkg::CNT_DIGITS, dif_pkg::GATE_ALL, dif_pkg::JC_PHASE, dif_pkg::STEP_RPAD};
         dif_pkg::STEP_RPAD:  ctrl_word = '{dif_pkg::DP_EMIT, dif_pkg::CS_SPACE,
            dif_pkg::CNT_PAD, dif_pkg::GATE_RIGHT, dif_pkg::JC_PHASE, dif_pkg::STEP_IDLE};
         default:             ctrl_word = '{dif_pkg::DP_HOLD, dif_pkg::CS_SPACE,
            dif_pkg::CNT_PAD, dif_pkg::GATE_ALL, dif_pkg::JC_ALWAYS, dif_pkg::STEP_IDLE};
      endcase
   end

endmodule

FILE: rtl/core/dif_sequencer.sv
// step counter with conditional jumps
module dif_sequencer (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  dif_pkg::ctrl_word_type ctrl_word,
   input  dif_pkg::dp_status_type status,
   output dif_pkg::step_type      step,
   output logic                   busy
);

   dif_pkg::step_type step_ff;
   dif_pkg::step_type step_in;
   logic              take;

   always_comb begin
      case (ctrl_word.jump_cond)
         dif_pkg::JC_START:  take = start;
         dif_pkg::JC_CONV:   take = status.conv_done;
         dif_pkg::JC_PHASE:  take = status.phase_done;
         dif_pkg::JC_ALWAYS: take = 1'b1;
         default:            take = 1'b1;
      endcase
      step_in = take ? ctrl_word.target : step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= dif_pkg::STEP_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;
   assign busy = (step_ff != dif_pkg::STEP_IDLE);

endmodule

FILE: rtl/core/dif_datapath.sv
// operand registers, digit conversion, field sizing and character output
module dif_datapath #(
   parameter int MAX_FIELD = dif_pkg::MAX_FIELD_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  dif_pkg::req_payload_type req_data,
   input  dif_pkg::ctrl_word_type   ctrl_word,
   output dif_pkg::dp_status_type   status,
   output logic                     rsp_valid,
   output dif_pkg::rsp_payload_type rsp_data
);

   localparam int         CW   = $clog2(MAX_FIELD + 1);
   localparam int         DW   = dif_pkg::MAX_DIGITS * dif_pkg::DIGIT_BITS;
   localparam logic [6:0] WMAX = 7'(MAX_FIELD);
   localparam logic [5:0] PMAX = 6'(MAX_FIELD - 1);

   logic [31:0]              mag_ff;
   logic [DW-1:0]            dig_ff;
   logic [3:0]               nd_ff;
   logic                     has_sign_ff;
   logic [7:0]               sign_char_ff;
   dif_pkg::flag_type        flag_ff;
   logic [CW-1:0]            width_ff;
   logic [5:0]               prec_ff;
   logic [5:0]               zeros_ff;
   logic [CW-1:0]            pad_ff;
   logic [CW-1:0]            remain_ff;
   logic [CW-1:0]            pcnt_ff;
   logic                     rsp_valid_ff;
   dif_pkg::rsp_payload_type rsp_data_ff;

   // operand load
   logic [31:0]       raw;
   logic              neg;
   logic [31:0]       mag_load;
   dif_pkg::flag_type flag_load;
   logic              sign_load;
   logic [7:0]        sign_char_load;

   always_comb begin
      if (req_data.short_length) begin
         if (req_data.operation == dif_pkg::OP_SIGNED) begin
            raw = {{16{req_data.value[15]}}, req_data.value[15:0]};
         end else begin
            raw = {16'h0000, req_data.value[15:0]};
         end
      end else begin
         raw = req_data.value;
      end
      neg      = (req_data.operation == dif_pkg::OP_SIGNED) && raw[31];
      mag_load = neg ? (32'd0 - raw) : raw;
      case (req_data.flag_mode)
         dif_pkg::FLAG_LEFT:  flag_load = dif_pkg::FLAG_LEFT;
         dif_pkg::FLAG_PLUS:  flag_load = dif_pkg::FLAG_PLUS;
         dif_pkg::FLAG_SPACE: flag_load = dif_pkg::FLAG_SPACE;
         dif_pkg::FLAG_ZERO:  flag_load = dif_pkg::FLAG_ZERO;
         default:             flag_load = dif_pkg::FLAG_NONE;
      endcase
      sign_load      = 1'b0;
      sign_char_load = dif_pkg::CH_SPACE;
      if (neg) begin
         sign_load      = 1'b1;
         sign_char_load = dif_pkg::CH_MINUS;
      end else if (req_data.operation == dif_pkg::OP_SIGNED) begin
         if (flag_load == dif_pkg::FLAG_PLUS) begin
            sign_load      = 1'b1;
            sign_char_load = dif_pkg::CH_PLUS;
         end else if (flag_load == dif_pkg::FLAG_SPACE) begin
            sign_load      = 1'b1;
            sign_char_load = dif_pkg::CH_SPACE;
         end
      end
   end

   // one digit per step, divide by ten through the reciprocal
   logic [63:0] prod;
   logic [31:0] quot;
   logic [31:0] rem;

   always_comb begin
      prod = 64'(mag_ff) * 64'(dif_pkg::RECIP10);
      quot = 32'(prod >> dif_pkg::RECIP_SHIFT);
      rem  = mag_ff - ((quot << 3) + (quot << 1));
   end

   assign status.conv_done = (quot == 32'd0) || (nd_ff == 4'(dif_pkg::MAX_DIGITS - 1));

   // field sizing
   logic [5:0]    zeros_calc;
   logic [CW-1:0] body;

   always_comb begin
      zeros_calc = (prec_ff > {2'b00, nd_ff}) ? (prec_ff - {2'b00, nd_ff}) : 6'd0;
      body       = CW'(has_sign_ff) + CW'(zeros_calc) + CW'(nd_ff);
   end

   // phase counting and character select
   logic [CW-1:0] cnt;
   logic          gate_ok;
   logic [CW-1:0] eff;
   logic [7:0]    ch;

   always_comb begin
      case (ctrl_word.cnt_sel)
         dif_pkg::CNT_PAD:    cnt = pad_ff;
         dif_pkg::CNT_SIGN:   cnt = CW'(has_sign_ff);
         dif_pkg::CNT_ZEROS:  cnt = CW'(zeros_ff);
         dif_pkg::CNT_DIGITS: cnt = CW'(nd_ff);
         default:             cnt = '0;
      endcase
      case (ctrl_word.gate)
         dif_pkg::GATE_ALL:   gate_ok = 1'b1;
         dif_pkg::GATE_LEAD:  gate_ok = (flag_ff != dif_pkg::FLAG_LEFT) &&
                                        (flag_ff != dif_pkg::FLAG_ZERO);
         dif_pkg::GATE_ZERO:  gate_ok = (flag_ff == dif_pkg::FLAG_ZERO);
         dif_pkg::GATE_RIGHT: gate_ok = (flag_ff == dif_pkg::FLAG_LEFT);
         default:             gate_ok = 1'b0;
      endcase
      eff = gate_ok ? cnt : '0;
      case (ctrl_word.char_sel)
         dif_pkg::CS_SPACE: ch = dif_pkg::CH_SPACE;
         dif_pkg::CS_ZERO:  ch = dif_pkg::CH_ZERO;
         dif_pkg::CS_SIGN:  ch = sign_char_ff;
         dif_pkg::CS_DIGIT: ch = dif_pkg::CH_ZERO + {4'h0, dig_ff[3:0]};
         default:           ch = dif_pkg::CH_SPACE;
      endcase
   end

   assign status.phase_done = (eff == '0) || (CW'(pcnt_ff + 1'b1) == eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pcnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (ctrl_word.dp_op)
            dif_pkg::DP_LOAD: begin
               if (start) begin
                  mag_ff       <= mag_load;
                  nd_ff        <= 4'd0;
                  has_sign_ff  <= sign_load;
                  sign_char_ff <= sign_char_load;
                  flag_ff      <= flag_load;
                  width_ff     <= CW'((req_data.field_width > WMAX) ? WMAX
                                                                    : req_data.field_width);
                  prec_ff      <= (req_data.min_digits > PMAX) ? PMAX : req_data.min_digits;
                  pcnt_ff      <= '0;
               end
            end
            dif_pkg::DP_CONV: begin
               mag_ff <= quot;
               dig_ff <= {dig_ff[DW-dif_pkg::DIGIT_BITS-1:0], rem[3:0]};
               nd_ff  <= nd_ff + 4'd1;
            end
            dif_pkg::DP_CALC: begin
               zeros_ff  <= zeros_calc;
               pad_ff    <= (width_ff > body) ? (width_ff - body) : '0;
               remain_ff <= (width_ff > body) ? width_ff : body;
            end
            dif_pkg::DP_EMIT: begin
               if (eff != '0) begin
                  rsp_valid_ff          <= 1'b1;
                  rsp_data_ff.out_char  <= ch;
                  rsp_data_ff.last_char <= (remain_ff == CW'(1));
                  remain_ff             <= remain_ff - 1'b1;
                  pcnt_ff               <= status.phase_done ? '0 : CW'(pcnt_ff + 1'b1);
                  if (ctrl_word.char_sel == dif_pkg::CS_DIGIT) begin
                     dig_ff <= dig_ff >> dif_pkg::DIGIT_BITS;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/core/decimal_integer_formatter_core.sv
// top level of the decimal integer formatter: control store, sequencer and datapath
//
//   channel  ports                       handshake
//   request  start, busy, req_data       taken when start is high and busy is low
//   result   rsp_valid, rsp_data         one character per strobe, last_char marks the end
//
// a request converts d digits (1..10), then emits its characters in the phases leading pad,
// sign, zero pad, precision zeros, digits and right pad; up to 5 of these phases may be empty
// the digit loop runs one divide-by-ten per cycle through a single reciprocal multiplier
// reset clears the step counter and the result strobe; no clearing pass
// results cannot be stalled; the last character's strobe may share a cycle with
// the acceptance of the next request
`include "decimal_integer_formatter_core_macros.svh"

module decimal_integer_formatter_core #(
   parameter int MAX_FIELD = dif_pkg::MAX_FIELD_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  dif_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   output dif_pkg::rsp_payload_type rsp_data
);

   dif_pkg::step_type      step;
   dif_pkg::ctrl_word_type ctrl_word;
   dif_pkg::dp_status_type status;

   dif_ucode_rom u_rom (
      .step      (step),
      .ctrl_word (ctrl_word)
   );

   dif_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .ctrl_word (ctrl_word),
      .status    (status),
      .step      (step),
      .busy      (busy)
   );

   dif_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .ctrl_word (ctrl_word),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a taken request holds the block busy
   `DIF_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // the final character ends the strobe run
   `DIF_ASSERT_NEXT(a_last_ends, clock, reset, rsp_valid && rsp_data.last_char, !rsp_valid)
   // more characters still to come means the request is in flight
   `DIF_ASSERT_NOW(a_mid_busy, clock, reset, rsp_valid && !rsp_data.last_char, busy)

endmodule

FILE: verif/decimal_integer_formatter_core_tb.sv
// self-checking testbench for decimal_integer_formatter_core: directed and random requests
`timescale 1ns / 1ps

module decimal_integer_formatter_core_tb;

   localparam int FIELD_LIMIT = dif_pkg::MAX_FIELD_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_REQUESTS = 148;

   class field_scoreboard;
      dif_pkg::rsp_payload_type expected_chars[$];
      int mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_chars.size();
      endfunction

      // work out the characters one request produces and queue them
      function void note_request(dif_pkg::req_payload_type req);
         dif_pkg::flag_type flag;
         int unsigned width, prec, nd, zeros, body, pad, n;
         logic [31:0] raw, mag;
         logic [7:0] sign_char;
         bit has_sign;
         logic [7:0] digit_chars[dif_pkg::MAX_DIGITS];
         logic [7:0] chars[$];
         dif_pkg::rsp_payload_type item;

         flag = (req.flag_mode > dif_pkg::FLAG_ZERO) ? dif_pkg::FLAG_NONE
                                                     : dif_pkg::flag_type'(req.flag_mode);
         width = 32'(req.field_width);
         if (width > FIELD_LIMIT) width = FIELD_LIMIT;
         prec = 32'(req.min_digits);
         if (prec > FIELD_LIMIT - 1) prec = FIELD_LIMIT - 1;

         raw = req.value;
         if (req.short_length) begin
            if (req.operation == dif_pkg::OP_SIGNED) raw = {{16{raw[15]}}, raw[15:0]};
            else raw = {16'h0000, raw[15:0]};
         end
         mag = raw;
         has_sign = 1'b0;
         sign_char = dif_pkg::CH_SPACE;
         if (req.operation == dif_pkg::OP_SIGNED) begin
            if (raw[31]) begin
               mag = -raw;
               has_sign = 1'b1;
               sign_char = dif_pkg::CH_MINUS;
            end else if (flag == dif_pkg::FLAG_PLUS) begin
               has_sign = 1'b1;
               sign_char = dif_pkg::CH_PLUS;
            end else if (flag == dif_pkg::FLAG_SPACE) begin
               has_sign = 1'b1;
               sign_char = dif_pkg::CH_SPACE;
            end
         end

         nd = 0;
         do begin
            digit_chars[nd] = dif_pkg::CH_ZERO + 8'(mag % 10);
            mag = mag / 10;
            nd++;
         end while (mag != 0 && nd < dif_pkg::MAX_DIGITS);

         zeros = (prec > nd) ? prec - nd : 0;
         body = has_sign + zeros + nd;
         pad = (width > body) ? width - body : 0;

         if (flag != dif_pkg::FLAG_LEFT && flag != dif_pkg::FLAG_ZERO)
            repeat (pad) chars.push_back(dif_pkg::CH_SPACE);
         if (has_sign) chars.push_back(sign_char);
         if (flag == dif_pkg::FLAG_ZERO) repeat (pad) chars.push_back(dif_pkg::CH_ZERO);
         repeat (zeros) chars.push_back(dif_pkg::CH_ZERO);
         for (int i = nd; i > 0; i--) chars.push_back(digit_chars[i - 1]);
         if (flag == dif_pkg::FLAG_LEFT) repeat (pad) chars.push_back(dif_pkg::CH_SPACE);

         n = (chars.size() > FIELD_LIMIT) ? FIELD_LIMIT : chars.size();
         for (int i = 0; i < n; i++) begin
            item.out_char = chars[i];
            item.last_char = (i == n - 1);
            expected_chars.push_back(item);
         end
      endfunction

      function void check_char(dif_pkg::rsp_payload_type got);
         dif_pkg::rsp_payload_type want;
         if (expected_chars.size() == 0) begin
            $error("unexpected character %h, nothing pending", got.out_char);
            mismatch_count++;
            return;
         end
         want = expected_chars.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
            mismatch_count++;
         end
         if (got.last_char !== want.last_char) begin
            $error("last_char: expected %b, actual %b", want.last_char, got.last_char);
            mismatch_count++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   dif_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   dif_pkg::rsp_payload_type rsp_data;

   field_scoreboard scoreboard;
   int              sent_count;
   int              cycle_count;

   decimal_integer_formatter_core i_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) scoreboard.check_char(rsp_data);
   end

   function automatic dif_pkg::req_payload_type make_request(logic op, logic [31:0] value,
                                                             logic shrt, logic [2:0] flag,
                                                             logic [6:0] width,
                                                             logic [5:0] prec);
      dif_pkg::req_payload_type req;
      req.operation    = op;
      req.value        = value;
      req.short_length = shrt;
      req.flag_mode    = flag;
      req.field_width  = width;
      req.min_digits   = prec;
      return req;
   endfunction

   function automatic dif_pkg::req_payload_type random_request();
      logic [31:0] value;
      logic [6:0]  width;
      logic [5:0]  prec;
      case ($urandom_range(0, 5))
         0: value = $urandom_range(0, 9);
         1: value = $urandom_range(0, 99999);
         2: value = $urandom();
         3: value = 32'h8000_0000 + $urandom_range(0, 15);
         4: value = 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: value = 32'h7FFF_FFFF - $urandom_range(0, 15);
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: width = 7'($urandom_range(0, 16));
         6, 7: width = 7'($urandom_range(17, 40));
         8: width = 7'($urandom_range(41, 64));
         default: width = 7'($urandom_range(65, 127));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: prec = 6'($urandom_range(0, 12));
         6, 7: prec = 6'($urandom_range(13, 30));
         default: prec = 6'($urandom_range(31, 63));
      endcase
      return make_request(1'($urandom_range(0, 1)), value, ($urandom_range(0, 3) == 0),
                          3'($urandom_range(0, 7)), width, prec);
   endfunction

   // present one request, wait for it to be taken, then maybe leave a gap
   task automatic send_request(dif_pkg::req_payload_type req);
      start <= 1'b1;
      req_data <= req;
      do @(posedge clock); while (busy);
      scoreboard.note_request(req);
      sent_count++;
      if ((sent_count < 80 || sent_count >= 140) && $urandom_range(99) < 26) begin
         start <= 1'b0;
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(10, 90)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      sent_count = 0;
      scoreboard = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(dif_pkg::OP_SIGNED, 32'd0, 1'b0, dif_pkg::FLAG_NONE,
                                7'd0, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'h8000_0000, 1'b0, dif_pkg::FLAG_NONE,
                                7'd0, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'h7FFF_FFFF, 1'b0, dif_pkg::FLAG_PLUS,
                                7'd0, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'h1234_8000, 1'b1, dif_pkg::FLAG_SPACE,
                                7'd0, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'hFFFF_7FFF, 1'b1, dif_pkg::FLAG_SPACE,
                                7'd0, 6'd0));
      send_request(make_request(dif_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 1'b0, dif_pkg::FLAG_PLUS,
                                7'd0, 6'd0));
      send_request(make_request(dif_pkg::OP_UNSIGNED, 32'hABCD_8000, 1'b1,
                                dif_pkg::FLAG_SPACE, 7'd8, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'hFFFF_FF85, 1'b0, dif_pkg::FLAG_ZERO,
                                7'd12, 6'd5));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd42, 1'b0, dif_pkg::FLAG_ZERO,
                                7'd10, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'hFFFF_FFFF, 1'b0, dif_pkg::FLAG_LEFT,
                                7'd20, 6'd3));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd917, 1'b0, dif_pkg::FLAG_NONE,
                                7'd15, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd917, 1'b0, dif_pkg::FLAG_PLUS,
                                7'd15, 6'd6));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd5, 1'b0, 3'd5, 7'd4, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd6, 1'b0, 3'd6, 7'd4, 6'd2));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd7, 1'b0, 3'd7, 7'd4, 6'd0));
      send_request(make_request(dif_pkg::OP_UNSIGNED, 32'd0, 1'b0, dif_pkg::FLAG_ZERO,
                                7'd64, 6'd0));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd123, 1'b0, dif_pkg::FLAG_NONE,
                                7'd127, 6'd0));
      send_request(make_request(dif_pkg::OP_UNSIGNED, 32'd99, 1'b0, dif_pkg::FLAG_NONE,
                                7'd0, 6'd63));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'h8000_0000, 1'b0, dif_pkg::FLAG_ZERO,
                                7'd127, 6'd63));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'd1, 1'b0, dif_pkg::FLAG_SPACE,
                                7'd64, 6'd63));
      send_request(make_request(dif_pkg::OP_SIGNED, 32'h0000_7FFF, 1'b1, dif_pkg::FLAG_LEFT,
                                7'd127, 6'd0));
      send_request(make_request(dif_pkg::OP_UNSIGNED, 32'hFFFF_FFFF, 1'b1, dif_pkg::FLAG_ZERO,
                                7'd3, 6'd0));

      repeat (RANDOM_REQUESTS) send_request(random_request());
      start <= 1'b0;

      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (scoreboard.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
